// ===== design/stsp_pkg.sv =====
// Package for the string-table stream parser.
// Holds field widths, role and status codes, record phases, register map and the magic bytes.
// No dependencies.
package stsp_pkg;

	localparam int POS_W   = 17;
	localparam int WORD_W  = 16;
	localparam int LEFT_W  = 17;
	localparam int HDR_W   = 7;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [POS_W-1:0] POS_MAX  = '1;
	localparam logic [POS_W-1:0] SEEN_MAX = '1;
	localparam logic [HDR_W-1:0] HDR_MIN  = 7'd12;
	localparam logic [POS_W-1:0] MIN_LEN_M1 = 17'd11;

	// byte roles
	localparam logic [2:0] ROLE_HEADER  = 3'd0;
	localparam logic [2:0] ROLE_IGNORED = 3'd4;

	// parse status / error codes
	localparam logic [2:0] ST_RUN     = 3'd0;
	localparam logic [2:0] ST_OK      = 3'd1;
	localparam logic [2:0] ST_SHORT   = 3'd2;
	localparam logic [2:0] ST_MAGIC   = 3'd3;
	localparam logic [2:0] ST_SIZE    = 3'd4;
	localparam logic [2:0] ST_VERSION = 3'd5;
	localparam logic [2:0] ST_TRUNC   = 3'd6;
	localparam logic [2:0] ST_COUNT   = 3'd7;

	// register indexes
	localparam logic [1:0] REG_DENSE_VER  = 2'd0;
	localparam logic [1:0] REG_TAGGED_VER = 2'd1;
	localparam logic [1:0] REG_DENSE_HDR  = 2'd2;
	localparam logic [1:0] REG_TAGGED_HDR = 2'd3;

	typedef enum logic [2:0] {
		PH_HEADER = 3'd0,
		PH_LENGTH = 3'd1,
		PH_TEXT   = 3'd2,
		PH_ID     = 3'd3
	} phase_t;

	typedef struct packed {
		logic [WORD_W-1:0] dense_version_code;
		logic [WORD_W-1:0] tagged_version_code;
		logic [HDR_W-1:0]  dense_header_bytes;
		logic [HDR_W-1:0]  tagged_header_bytes;
	} cfg_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h58;
			2'd1:    r = 8'h55;
			2'd2:    r = 8'h49;
			default: r = 8'h53;
		endcase
		return r;
	endfunction

endpackage

// ===== design/stsp_channels.sv =====
// Valid/ready channel interfaces of the string-table stream parser.
// stsp_in_if carries file bytes, stsp_out_if carries per-byte results. No dependencies.
interface stsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] file_byte;
	logic       final_byte;
	modport source(output valid, file_byte, final_byte, input ready);
	modport sink(input valid, file_byte, final_byte, output ready);
endinterface

interface stsp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  byte_role;
	logic [15:0] entry_index;
	logic        entry_done;
	logic [31:0] entry_tag;
	logic [15:0] entry_chars;
	logic [2:0]  parse_status;
	modport source(output valid, byte_role, entry_index, entry_done, entry_tag,
		entry_chars, parse_status, input ready);
	modport sink(input valid, byte_role, entry_index, entry_done, entry_tag,
		entry_chars, parse_status, output ready);
endinterface

// ===== design/string_table_stream_parser.sv =====
// Top level of the string-table stream parser.
// Depends on stsp_pkg, stsp_channels (stsp_in_if, stsp_out_if) and stsp_regs.
//
// Usage:
//  stream : one file byte per item, final_byte set on the last byte of a file.
//  result : one item per input byte: role, record index, record-complete flag,
//           record id, character count, and on the last byte the parse status
//           (ok or the lowest-coded error found).
//  APB    : four registers at byte addresses 0, 4, 8, 12 (dense version code,
//           tagged version code, dense header bytes, tagged header bytes);
//           write only while no item is in flight. pready is tied high.
// Timing: an accepted byte waits in an input register; the parse step runs from
// there into the result register, which offers the result. One byte per cycle
// is sustained while the result side takes every item.
// If the result side stalls, the result register holds; the input register
// still takes one more item, after which stream.ready drops until the result
// is taken.
// Reset clears the parse state and loads register defaults; after the last
// byte of a file the parse state returns to its reset value.
module string_table_stream_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	stsp_in_if.sink                      stream,
	stsp_out_if.source                   result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [stsp_pkg::ADDR_W-1:0]  paddr,
	input  logic [stsp_pkg::DATA_W-1:0]  pwdata,
	output logic [stsp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import stsp_pkg::*;

	cfg_t cfg;

	stsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign pready = 1'b1;

	// input stage
	logic       valid_s1;
	logic [7:0] file_byte_s1;
	logic       final_byte_s1;
	logic       advance;

	// parse state
	logic [POS_W-1:0]  pos_q,   pos_n;
	logic [WORD_W-1:0] size_q,  size_n;
	logic [WORD_W-1:0] count_q, count_n;
	logic [WORD_W-1:0] ver_q,   ver_n;
	logic [POS_W-1:0]  seen_q,  seen_n;
	phase_t            phase_q, phase_n;
	logic [LEFT_W-1:0] left_q,  left_n;
	logic [31:0]       shift_q, shift_n;
	logic [2:0]        fe_q,    fe_n;
	logic [WORD_W-1:0] rc_q,    rc_n;

	// step results
	logic [2:0]        role_c;
	logic [WORD_W-1:0] idx_c;
	logic              done_c;
	logic [31:0]       tag_c;
	logic [WORD_W-1:0] chars_c;
	logic [2:0]        status_c;

	// result register
	logic              out_valid_q;
	logic [2:0]        role_q;
	logic [WORD_W-1:0] idx_q;
	logic              done_q;
	logic [31:0]       tag_q;
	logic [WORD_W-1:0] chars_q;
	logic [2:0]        status_q;

	assign advance      = valid_s1 & (~out_valid_q | result.ready);
	assign stream.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.valid && stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			file_byte_s1  <= stream.file_byte;
			final_byte_s1 <= stream.final_byte;
		end
	end

	// per-byte parse step
	always_comb begin
		logic [7:0]        b;
		logic [POS_W-1:0]  p;
		logic              err_magic, err_size, err_ver;
		logic [2:0]        cand;
		logic              dense;
		logic [HDR_W-1:0]  hdr_raw, hdr;
		logic [POS_W:0]    len;
		logic [POS_W:0]    expect_cnt;
		logic [2:0]        e;

		b = file_byte_s1;
		p = pos_q;

		pos_n   = pos_q;
		size_n  = size_q;
		count_n = count_q;
		ver_n   = ver_q;
		seen_n  = seen_q;
		phase_n = phase_q;
		left_n  = left_q;
		shift_n = shift_q;
		fe_n    = fe_q;
		rc_n    = rc_q;

		role_c   = ROLE_HEADER;
		idx_c    = '0;
		done_c   = 1'b0;
		tag_c    = '0;
		chars_c  = '0;
		status_c = ST_RUN;
		e        = ST_RUN;
		len      = '0;
		expect_cnt = '0;

		// header capture
		err_magic = (p < 17'd4) && (b != magic_byte(p[1:0]));
		if (p == 17'd4 || p == 17'd5) begin
			ver_n = {ver_q[7:0], b};
		end
		if (p == 17'd8 || p == 17'd9) begin
			size_n = {size_q[7:0], b};
		end
		if (p == 17'd10 || p == 17'd11) begin
			count_n = {count_q[7:0], b};
		end
		err_ver  = (p == 17'd5) && (ver_n != cfg.dense_version_code) &&
			(ver_n != cfg.tagged_version_code);
		err_size = (p >= 17'd9) && (p >= {1'b0, size_n});

		if (err_magic)     cand = ST_MAGIC;
		else if (err_size) cand = ST_SIZE;
		else if (err_ver)  cand = ST_VERSION;
		else               cand = ST_RUN;
		if (cand != ST_RUN && (fe_q == ST_RUN || cand < fe_q)) begin
			fe_n = cand;
		end

		dense   = (ver_n == cfg.dense_version_code);
		hdr_raw = dense ? cfg.dense_header_bytes : cfg.tagged_header_bytes;
		hdr     = (hdr_raw < HDR_MIN) ? HDR_MIN : hdr_raw;

		// record walk
		if (fe_q != ST_RUN) begin
			role_c = ROLE_IGNORED;
		end else if (p >= POS_W'(hdr)) begin
			if (phase_n == PH_HEADER) begin
				phase_n = PH_LENGTH;
				left_n  = 17'd2;
				shift_n = '0;
			end
			role_c = phase_n;
			idx_c  = dense ? WORD_W'(seen_q + 17'd1) : seen_q[WORD_W-1:0];
			unique case (phase_n)
				PH_LENGTH: begin
					shift_n = {shift_n[23:0], b};
					left_n  = left_n - 17'd1;
					if (left_n == '0) begin
						rc_n    = shift_n[WORD_W-1:0];
						chars_c = rc_n;
						shift_n = '0;
						if (rc_n != '0) begin
							phase_n = PH_TEXT;
							left_n  = {rc_n, 1'b0};
						end else if (dense) begin
							done_c = 1'b1;
						end else begin
							phase_n = PH_ID;
							left_n  = 17'd4;
						end
					end
				end
				PH_TEXT: begin
					chars_c = rc_q;
					left_n  = left_n - 17'd1;
					if (left_n == '0) begin
						if (dense) begin
							done_c = 1'b1;
						end else begin
							phase_n = PH_ID;
							left_n  = 17'd4;
							shift_n = '0;
						end
					end
				end
				default: begin
					chars_c = rc_q;
					shift_n = {shift_n[23:0], b};
					if (left_n != '0) begin
						left_n = left_n - 17'd1;
					end
					if (left_n == '0) begin
						done_c = 1'b1;
						tag_c  = shift_n;
					end
				end
			endcase
			if (done_c) begin
				if (seen_n != SEEN_MAX) begin
					seen_n = seen_n + 17'd1;
				end
				phase_n = PH_LENGTH;
				left_n  = 17'd2;
				shift_n = '0;
			end
		end

		// end of file
		if (final_byte_s1) begin
			len = {1'b0, p} + 18'd1;
			if (p < MIN_LEN_M1) begin
				status_c = ST_SHORT;
			end else begin
				e = fe_n;
				if (len != {2'b00, size_n} && (e == ST_RUN || e > ST_SIZE)) begin
					e = ST_SIZE;
				end
				if (e == ST_RUN) begin
					expect_cnt = dense ? ({1'b0, seen_n} + 18'd1) : {1'b0, seen_n};
					if (phase_n != PH_HEADER &&
						!(phase_n == PH_LENGTH && left_n == 17'd2)) begin
						e = ST_TRUNC;
					end else if (expect_cnt != {2'b00, count_n}) begin
						e = ST_COUNT;
					end else begin
						e = ST_OK;
					end
				end
				status_c = e;
			end
			pos_n   = '0;
			size_n  = '0;
			count_n = '0;
			ver_n   = '0;
			seen_n  = '0;
			phase_n = PH_HEADER;
			left_n  = '0;
			shift_n = '0;
			fe_n    = ST_RUN;
			rc_n    = '0;
		end else if (pos_q != POS_MAX) begin
			pos_n = pos_q + 17'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			size_q  <= '0;
			count_q <= '0;
			ver_q   <= '0;
			seen_q  <= '0;
			phase_q <= PH_HEADER;
			left_q  <= '0;
			shift_q <= '0;
			fe_q    <= ST_RUN;
			rc_q    <= '0;
		end else if (advance) begin
			pos_q   <= pos_n;
			size_q  <= size_n;
			count_q <= count_n;
			ver_q   <= ver_n;
			seen_q  <= seen_n;
			phase_q <= phase_n;
			left_q  <= left_n;
			shift_q <= shift_n;
			fe_q    <= fe_n;
			rc_q    <= rc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			role_q   <= role_c;
			idx_q    <= idx_c;
			done_q   <= done_c;
			tag_q    <= tag_c;
			chars_q  <= chars_c;
			status_q <= status_c;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.byte_role    = role_q;
	assign result.entry_index  = idx_q;
	assign result.entry_done   = done_q;
	assign result.entry_tag    = tag_q;
	assign result.entry_chars  = chars_q;
	assign result.parse_status = status_q;

`ifndef SYNTHESIS
	// records are only counted once the walk has started
	a_seen_header: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> seen_q == '0)
		else $error("records counted while still in header");

	// a text field is never left with nothing to consume
	a_text_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_TEXT |-> left_q != '0)
		else $error("text phase with zero bytes left");

	// only header errors are kept between bytes
	a_sticky_code: assert property (@(posedge clk) disable iff (!arst_n)
		fe_q == ST_RUN || fe_q == ST_MAGIC || fe_q == ST_SIZE || fe_q == ST_VERSION)
		else $error("unexpected sticky error code");

	// position steps by one on every non-final byte below saturation
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !final_byte_s1 && pos_q != POS_MAX |=> pos_q == $past(pos_q) + 17'd1)
		else $error("byte position did not advance");

	// ignored bytes carry no record information
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && role_q == ROLE_IGNORED |-> idx_q == '0 && !done_q && chars_q == '0)
		else $error("ignored item carries record fields");
`endif

endmodule

// ===== design/stsp_regs.sv =====
// APB-style configuration registers of the string-table stream parser.
// Depends on stsp_pkg.
module stsp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [stsp_pkg::ADDR_W-1:0]  paddr,
	input  logic [stsp_pkg::DATA_W-1:0]  pwdata,
	output logic [stsp_pkg::DATA_W-1:0]  prdata,
	output stsp_pkg::cfg_t               cfg
);
	import stsp_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dense_version_code  <= 16'd1;
			cfg_q.tagged_version_code <= 16'd2;
			cfg_q.dense_header_bytes  <= 7'd14;
			cfg_q.tagged_header_bytes <= 7'd12;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_DENSE_VER:  cfg_q.dense_version_code  <= pwdata[WORD_W-1:0];
				REG_TAGGED_VER: cfg_q.tagged_version_code <= pwdata[WORD_W-1:0];
				REG_DENSE_HDR:  cfg_q.dense_header_bytes  <= pwdata[HDR_W-1:0];
				REG_TAGGED_HDR: cfg_q.tagged_header_bytes <= pwdata[HDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DENSE_VER:  prdata = DATA_W'(cfg_q.dense_version_code);
			REG_TAGGED_VER: prdata = DATA_W'(cfg_q.tagged_version_code);
			REG_DENSE_HDR:  prdata = DATA_W'(cfg_q.dense_header_bytes);
			REG_TAGGED_HDR: prdata = DATA_W'(cfg_q.tagged_header_bytes);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== tb/sv/stsp_tb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the string-table stream parser testbench: per-byte report type,
// a byte-level parse predictor and the queue of predicted reports.
// Depends on stsp_pkg.
package stsp_tb_pkg;
	import stsp_pkg::*;

	localparam logic [7:0] MAGIC [4] = '{8'h58, 8'h55, 8'h49, 8'h53};
	localparam logic [2:0] NO_ERR = ST_RUN;

	typedef struct packed {
		logic [2:0]  role;
		logic [15:0] index;
		logic        done;
		logic [31:0] tag;
		logic [15:0] chars;
		logic [2:0]  status;
	} byte_report_t;

	class parse_scoreboard;
		cfg_t          cfg;
		logic [16:0]   pos;
		logic [15:0]   size_field;
		logic [15:0]   count_field;
		logic [15:0]   version;
		logic [16:0]   records;
		phase_t        phase;
		logic [16:0]   left;
		logic [31:0]   shift;
		logic [2:0]    err;
		logic [15:0]   chars_now;
		byte_report_t  reports[$];
		int unsigned   mismatches;

		function new();
			cfg.dense_version_code = 16'd1;
			cfg.tagged_version_code = 16'd2;
			cfg.dense_header_bytes = 7'd14;
			cfg.tagged_header_bytes = 7'd12;
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			pos = '0;
			size_field = '0;
			count_field = '0;
			version = '0;
			records = '0;
			phase = PH_HEADER;
			left = '0;
			shift = '0;
			err = NO_ERR;
			chars_now = '0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_DENSE_VER:  cfg.dense_version_code = v[15:0];
				REG_TAGGED_VER: cfg.tagged_version_code = v[15:0];
				REG_DENSE_HDR:  cfg.dense_header_bytes = v[6:0];
				default:        cfg.tagged_header_bytes = v[6:0];
			endcase
		endfunction

		function void flag(logic [2:0] code);
			if (err == NO_ERR || code < err)
				err = code;
		endfunction

		function void count_mismatch(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		// predicts the report for one accepted file byte
		function void take_byte(logic [7:0] b, logic fin);
			int unsigned  p;
			int unsigned  hdr;
			int unsigned  want;
			bit           ignored;
			bit           dense;
			logic [2:0]   e;
			logic [16:0]  idx;
			byte_report_t r;
			p = 32'(pos);
			ignored = (err != NO_ERR);
			r = '0;
			if (p < 4) begin
				if (b != MAGIC[p])
					flag(ST_MAGIC);
			end else if (p == 4 || p == 5) begin
				version = {version[7:0], b};
				if (p == 5 && version != cfg.dense_version_code &&
						version != cfg.tagged_version_code)
					flag(ST_VERSION);
			end else if (p == 8 || p == 9) begin
				size_field = {size_field[7:0], b};
			end else if (p == 10 || p == 11) begin
				count_field = {count_field[7:0], b};
			end
			if (p >= 9 && p + 1 > size_field)
				flag(ST_SIZE);

			dense = (version == cfg.dense_version_code);
			hdr = dense ? 32'(cfg.dense_header_bytes) : 32'(cfg.tagged_header_bytes);
			if (hdr < 12)
				hdr = 12;

			if (ignored) begin
				r.role = ROLE_IGNORED;
			end else if (p >= hdr) begin
				if (phase == PH_HEADER) begin
					phase = PH_LENGTH;
					left = 17'd2;
					shift = '0;
				end
				r.role = phase;
				idx = dense ? records + 17'd1 : records;
				r.index = idx[15:0];
				case (phase)
					PH_LENGTH: begin
						shift = {shift[23:0], b};
						left--;
						if (left == 0) begin
							chars_now = shift[15:0];
							r.chars = chars_now;
							shift = '0;
							if (chars_now != 0) begin
								phase = PH_TEXT;
								left = {chars_now, 1'b0};
							end else if (dense) begin
								r.done = 1'b1;
							end else begin
								phase = PH_ID;
								left = 17'd4;
							end
						end
					end
					PH_TEXT: begin
						r.chars = chars_now;
						left--;
						if (left == 0) begin
							if (dense) begin
								r.done = 1'b1;
							end else begin
								phase = PH_ID;
								left = 17'd4;
								shift = '0;
							end
						end
					end
					default: begin
						r.chars = chars_now;
						shift = {shift[23:0], b};
						if (left > 0)
							left--;
						if (left == 0) begin
							r.done = 1'b1;
							r.tag = shift;
						end
					end
				endcase
				if (r.done) begin
					if (records != SEEN_MAX)
						records++;
					phase = PH_LENGTH;
					left = 17'd2;
					shift = '0;
				end
			end else begin
				r.role = ROLE_HEADER;
			end

			if (fin) begin
				if (p + 1 < 12) begin
					r.status = ST_SHORT;
				end else begin
					e = err;
					if (p + 1 != size_field && (e == NO_ERR || e > ST_SIZE))
						e = ST_SIZE;
					if (e == NO_ERR) begin
						want = dense ? 32'(records) + 1 : 32'(records);
						if (phase != PH_HEADER && !(phase == PH_LENGTH && left == 2))
							e = ST_TRUNC;
						else if (want != count_field)
							e = ST_COUNT;
						else
							e = ST_OK;
					end
					r.status = e;
				end
				clear();
			end else if (pos != POS_MAX) begin
				pos++;
			end
			reports.push_back(r);
		endfunction

		function void check_report(byte_report_t got);
			byte_report_t want;
			if (reports.size() == 0) begin
				count_mismatch($sformatf("unexpected item: role %0d index %0d status %0d",
					got.role, got.index, got.status));
				return;
			end
			want = reports.pop_front();
			if (got.role !== want.role || got.index !== want.index ||
					got.done !== want.done || got.tag !== want.tag ||
					got.chars !== want.chars || got.status !== want.status)
				count_mismatch($sformatf({"item mismatch: expected role %0d index %0d ",
					"done %0d tag %h chars %0d status %0d, got role %0d index %0d ",
					"done %0d tag %h chars %0d status %0d"},
					want.role, want.index, want.done, want.tag, want.chars, want.status,
					got.role, got.index, got.done, got.tag, got.chars, got.status));
		endfunction
	endclass

endpackage

// ===== tb/sv/tb_string_table_stream_parser.sv =====
`timescale 1ns / 100ps
// Testbench for string_table_stream_parser: streams well-formed and damaged
// string-table files, predicts each per-byte item and checks it field by field.
// Depends on stsp_pkg, stsp_channels and stsp_tb_pkg.
module tb_string_table_stream_parser;
	import stsp_pkg::*;
	import stsp_tb_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;

	typedef enum int {
		FL_NONE, FL_MAGIC, FL_VERSION, FL_SIZE_BIG, FL_SIZE_SMALL, FL_COUNT,
		FL_TRUNC, FL_SHORT, FL_EXTRA, FL_HDR_CUT, FL_MULTI, FL_NOISE
	} flaw_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	bit                tx_quiet;
	bit                rx_quiet;
	bit                hold_req;

	stsp_in_if  stream_if();
	stsp_out_if result_if();

	parse_scoreboard sb = new();

	string_table_stream_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.stream(stream_if),
		.result(result_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("string_table_stream_parser test failed");
		$finish;
	end

	always @(posedge clk) begin
		byte_report_t got;
		if (result_if.valid && result_if.ready) begin
			got.role = result_if.byte_role;
			got.index = result_if.entry_index;
			got.done = result_if.entry_done;
			got.tag = result_if.entry_tag;
			got.chars = result_if.entry_chars;
			got.status = result_if.parse_status;
			sb.check_report(got);
		end
	end

	// result side: random stalls per item, one long hold on request
	initial begin
		int unsigned gap;
		bit          held;
		held = 1'b0;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = rx_quiet ? 0 : $urandom_range(0, 9);
			if (hold_req && !held) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end
			if (gap != 0) begin
				@(negedge clk);
				result_if.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!(result_if.valid && result_if.ready));
		end
	end

	task automatic set_reg(logic [1:0] idx, logic [31:0] v);
		logic [31:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, v);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== v)
			sb.count_mismatch($sformatf("register %0d read: expected %h, got %h",
				idx, v, rd));
	endtask

	task automatic set_config(logic [15:0] dv, logic [15:0] tv, logic [6:0] dh,
			logic [6:0] th);
		set_reg(REG_DENSE_VER, dv);
		set_reg(REG_TAGGED_VER, tv);
		set_reg(REG_DENSE_HDR, dh);
		set_reg(REG_TAGGED_HDR, th);
	endtask

	task automatic send_range(ref logic [7:0] q[$], input int lo, input int hi);
		int unsigned gap;
		bit          fin;
		for (int i = lo; i < hi; i++) begin
			gap = tx_quiet ? 0 : $urandom_range(0, 9);
			fin = (i == q.size() - 1);
			if (gap != 0) begin
				@(negedge clk);
				stream_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk);
			stream_if.valid <= 1'b1;
			stream_if.file_byte <= q[i];
			stream_if.final_byte <= fin;
			do @(posedge clk); while (!(stream_if.valid && stream_if.ready));
			sb.take_byte(q[i], fin);
		end
	endtask

	// stop offering and wait until every predicted item has come back
	task automatic settle();
		@(negedge clk);
		stream_if.valid <= 1'b0;
		while (sb.reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic void make_file(input bit want_dense, input int nrec, input int maxc,
			input flaw_t flaw, output logic [7:0] q[$]);
		logic [15:0] ver;
		logic [15:0] size_w;
		logic [15:0] count_w;
		logic [15:0] c;
		logic [15:0] delta;
		logic [7:0]  flip;
		int unsigned hdr;
		int unsigned cut;
		bit          dense;
		ver = want_dense ? sb.cfg.dense_version_code : sb.cfg.tagged_version_code;
		dense = (ver == sb.cfg.dense_version_code);
		hdr = dense ? 32'(sb.cfg.dense_header_bytes) : 32'(sb.cfg.tagged_header_bytes);
		if (hdr < 12)
			hdr = 12;
		q = {MAGIC[0], MAGIC[1], MAGIC[2], MAGIC[3], ver[15:8], ver[7:0]};
		while (q.size() < hdr) q.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < nrec; i++) begin
			c = 16'($urandom_range(0, maxc));
			q.push_back(c[15:8]);
			q.push_back(c[7:0]);
			repeat (2 * c) q.push_back(8'($urandom_range(0, 255)));
			if (!dense)
				repeat (4) q.push_back(8'($urandom_range(0, 255)));
		end
		size_w = 16'(q.size());
		count_w = 16'(dense ? nrec + 1 : nrec);
		if (flaw == FL_MAGIC || flaw == FL_MULTI) begin
			flip = 8'($urandom_range(1, 255));
			cut = $urandom_range(0, 3);
			q[cut] = q[cut] ^ flip;
		end
		if (flaw == FL_VERSION || flaw == FL_MULTI) begin
			do ver = 16'($urandom_range(0, 65535));
			while (ver == sb.cfg.dense_version_code || ver == sb.cfg.tagged_version_code);
			q[4] = ver[15:8];
			q[5] = ver[7:0];
		end
		if (flaw == FL_SIZE_BIG || flaw == FL_MULTI)
			size_w = 16'(q.size() + $urandom_range(1, 3));
		if (flaw == FL_SIZE_SMALL)
			size_w = 16'($urandom_range(0, q.size() - 1));
		if (flaw == FL_COUNT) begin
			delta = 16'($urandom_range(1, 65535));
			count_w = count_w + delta;
		end
		if (flaw == FL_TRUNC && q.size() > hdr + 1) begin
			cut = $urandom_range(hdr + 1, q.size() - 1);
			while (q.size() > cut) void'(q.pop_back());
			size_w = 16'(cut);
		end
		if (flaw == FL_HDR_CUT && hdr > 12) begin
			cut = $urandom_range(12, hdr - 1);
			while (q.size() > cut) void'(q.pop_back());
			size_w = 16'(cut);
		end
		if (flaw == FL_EXTRA)
			repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
		q[8] = size_w[15:8];
		q[9] = size_w[7:0];
		q[10] = count_w[15:8];
		q[11] = count_w[7:0];
		if (flaw == FL_SHORT) begin
			cut = $urandom_range(1, 11);
			while (q.size() > cut) void'(q.pop_back());
		end
		if (flaw == FL_NOISE) begin
			q = {};
			repeat ($urandom_range(1, 40)) q.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	initial begin
		logic [7:0]  q[$];
		logic [15:0] dv;
		int          sent;
		int          r;
		flaw_t       flaw;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stream_if.valid = 1'b0;
		stream_if.file_byte = '0;
		stream_if.final_byte = 1'b0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one file per kind of damage, alternating layouts, reset register values
		for (int k = 0; k <= FL_NOISE; k++) begin
			make_file(k[0], 2, 1, flaw_t'(k), q);
			send_range(q, 0, q.size());
		end
		q = {8'hFF};
		send_range(q, 0, 1);
		settle();

		// extreme codes and header sizes
		set_config(16'hFFFF, 16'h0000, 7'd127, 7'd64);
		make_file(1'b1, 2, 2, FL_NONE, q);
		send_range(q, 0, q.size());
		make_file(1'b0, 2, 2, FL_NONE, q);
		send_range(q, 0, q.size());
		make_file(1'b0, 1, 1, FL_HDR_CUT, q);
		send_range(q, 0, q.size());
		settle();

		// equal version codes, header registers below the minimum
		set_config(16'h0007, 16'h0007, 7'd0, 7'd0);
		make_file(1'b0, 3, 2, FL_NONE, q);
		send_range(q, 0, q.size());
		settle();

		// layout switched while a tagged walk is under way
		set_config(16'd1, 16'd2, 7'd12, 7'd12);
		make_file(1'b0, 3, 1, FL_NONE, q);
		send_range(q, 0, 16);
		settle();
		set_reg(REG_DENSE_VER, 16'd2);
		send_range(q, 16, q.size());
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph > 0) begin
				dv = 16'($urandom_range(0, 65535));
				set_config(dv, ($urandom_range(0, 3) == 0) ? dv : 16'($urandom_range(0, 65535)),
					7'($urandom_range(0, 20)), 7'($urandom_range(0, 20)));
			end
			tx_quiet = (ph == 2 || ph == 3);
			rx_quiet = (ph == 2);
			if (ph == 3)
				hold_req = 1'b1;
			sent = 0;
			while (sent < 15) begin
				r = $urandom_range(0, 22);
				flaw = (r < 12) ? FL_NONE : flaw_t'(r - 11);
				make_file(1'($urandom_range(0, 1)), $urandom_range(0, 4),
					($urandom_range(0, 9) == 0) ? 20 : 3, flaw, q);
				send_range(q, 0, q.size());
				sent += q.size();
			end
			settle();
		end

		if (sb.mismatches == 0 && sb.reports.size() == 0)
			$display("string_table_stream_parser test passed");
		else
			$display("string_table_stream_parser test failed");
		$finish;
	end

endmodule
